/* rtl/core/iirl_pkg.sv */
// Shared types and codes for the indexed insert/remove list.
`timescale 1ns / 1ps

package iirl_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int WIDTH_DEF = 32;

	localparam int ACTION_W = 3;
	localparam int INDEX_W  = 8;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int FILL_W   = 7;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_READ   = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_WRITE  = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_POP    = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

	// Command broadcast from the decoder to every cell in the row.
	typedef struct packed {
		logic shift_up;
		logic shift_down;
		logic write;
	} cell_cmd_t;

endpackage

/* rtl/core/iirl_cell.sv */
// One storage cell of the list row, moving its word to or from its neighbours.
`timescale 1ns / 1ps

module iirl_cell #(
	parameter int WIDTH = iirl_pkg::WIDTH_DEF
) (
	input  logic               clk,
	input  iirl_pkg::cell_cmd_t cmd,
	input  logic               hit,
	input  logic               above,
	input  logic [WIDTH-1:0]   left_word,
	input  logic [WIDTH-1:0]   right_word,
	input  logic [WIDTH-1:0]   new_word,
	output logic [WIDTH-1:0]   word,
	output logic [WIDTH-1:0]   read_part
);

	logic [WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		if (cmd.shift_up) begin
			if (above) begin
				word_q <= left_word;
			end else if (hit) begin
				word_q <= new_word;
			end
		end else if (cmd.shift_down) begin
			if (above || hit) begin
				word_q <= right_word;
			end
		end else if (cmd.write && hit) begin
			word_q <= new_word;
		end
	end

	assign word      = word_q;
	assign read_part = hit ? word_q : '0;

endmodule

/* rtl/core/iirl_ctrl.sv */
// Request decoder: index adjustment, status and the command for the cell row.
`timescale 1ns / 1ps

module iirl_ctrl #(
	parameter int DEPTH = iirl_pkg::DEPTH_DEF,
	localparam int CNT_W = $clog2(DEPTH + 1),
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic                            en,
	input  logic [iirl_pkg::ACTION_W-1:0]   action,
	input  logic signed [iirl_pkg::INDEX_W-1:0] index,
	input  logic [CNT_W-1:0]                held,
	output iirl_pkg::cell_cmd_t             cmd,
	output logic [IDX_W-1:0]                pos,
	output logic                            read_en,
	output logic [iirl_pkg::STATUS_W-1:0]   status,
	output logic [CNT_W-1:0]                held_next
);

	localparam int AW = ((CNT_W > iirl_pkg::INDEX_W) ? CNT_W : iirl_pkg::INDEX_W) + 1;

	logic signed [AW-1:0] idx_ext;
	logic [AW-1:0] held_ext;
	logic [AW-1:0] adj;
	logic neg;
	logic acc_ok;
	logic ins_ok;
	logic full;
	logic [iirl_pkg::STATUS_W-1:0] acc_status;

	always_comb begin
		idx_ext  = AW'(index);
		held_ext = AW'(held);
		adj      = idx_ext[AW-1] ? (idx_ext + held_ext) : idx_ext;
		neg      = adj[AW-1];
		acc_ok   = !neg && (adj < held_ext);
		ins_ok   = !neg && (adj <= held_ext);
		full     = (held == CNT_W'(DEPTH));
		pos      = adj[IDX_W-1:0];

		if (neg) begin
			acc_status = iirl_pkg::ST_RANGE;
		end else if (!acc_ok) begin
			acc_status = (held == '0) ? iirl_pkg::ST_EMPTY : iirl_pkg::ST_RANGE;
		end else begin
			acc_status = iirl_pkg::ST_OK;
		end

		cmd       = '0;
		read_en   = 1'b0;
		status    = iirl_pkg::ST_OK;
		held_next = held;

		case (action)
			iirl_pkg::ACT_INSERT: begin
				if (!ins_ok) begin
					status = iirl_pkg::ST_RANGE;
				end else if (full) begin
					status = iirl_pkg::ST_FULL;
				end else begin
					cmd.shift_up = en;
					held_next    = held + CNT_W'(1);
				end
			end
			iirl_pkg::ACT_READ: begin
				status  = acc_status;
				read_en = acc_ok;
			end
			iirl_pkg::ACT_WRITE: begin
				status    = acc_status;
				cmd.write = en && acc_ok;
			end
			iirl_pkg::ACT_REMOVE, iirl_pkg::ACT_POP: begin
				status         = acc_status;
				read_en        = acc_ok && (action == iirl_pkg::ACT_POP);
				cmd.shift_down = en && acc_ok;
				if (acc_ok) begin
					held_next = held - CNT_W'(1);
				end
			end
			iirl_pkg::ACT_CLEAR: begin
				held_next = '0;
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/core/indexed_insert_remove_list_unit.sv */
// Top level of the indexed insert/remove list: request stage, cell row and result register.
//
// Channel | Handshake             | Payload
// --------+-----------------------+-----------------------------
// request | in_valid / in_ready   | action, index, value
// result  | out_valid / out_ready | read_value, status, fill
//
// One request is taken per cycle while the result is not stalled. The decode, the shift of
// the whole cell row and the read-out select share the request stage; the result register
// follows it. The next request sees the updated count.
// Reset clears the count and the valid flags; cell contents stay undefined until written.
// A stalled result holds the request stage, and a request stage that cannot advance
// holds in_ready low.
`timescale 1ns / 1ps

module indexed_insert_remove_list_unit #(
	parameter int DEPTH = iirl_pkg::DEPTH_DEF,
	parameter int WIDTH = iirl_pkg::WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [iirl_pkg::ACTION_W-1:0]         action,
	input  logic signed [iirl_pkg::INDEX_W-1:0]   index,
	input  logic [iirl_pkg::VALUE_W-1:0]          value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [iirl_pkg::VALUE_W-1:0]          read_value,
	output logic [iirl_pkg::STATUS_W-1:0]         status,
	output logic [iirl_pkg::FILL_W-1:0]           fill
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	logic                                vld_s1;
	logic [iirl_pkg::ACTION_W-1:0]       action_s1;
	logic signed [iirl_pkg::INDEX_W-1:0] index_s1;
	logic [WIDTH-1:0]                    word_s1;

	logic [CNT_W-1:0]                    held_q;
	logic                                out_valid_q;
	logic [iirl_pkg::VALUE_W-1:0]        read_value_q;
	logic [iirl_pkg::STATUS_W-1:0]       status_q;
	logic [iirl_pkg::FILL_W-1:0]         fill_q;

	logic                                advance;
	iirl_pkg::cell_cmd_t                 cmd;
	logic [IDX_W-1:0]                    pos;
	logic                                read_en;
	logic [iirl_pkg::STATUS_W-1:0]       status_d;
	logic [CNT_W-1:0]                    held_next;

	logic [WIDTH-1:0] words [DEPTH];
	logic [WIDTH-1:0] parts [DEPTH];
	logic [DEPTH-1:0] hit;
	logic [DEPTH-1:0] above;
	logic [WIDTH-1:0] read_word;

	assign advance  = vld_s1 && (!out_valid_q || out_ready);
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1 <= action;
			index_s1  <= index;
			word_s1   <= WIDTH'(value);
		end
	end

	iirl_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.en       (advance),
		.action   (action_s1),
		.index    (index_s1),
		.held     (held_q),
		.cmd      (cmd),
		.pos      (pos),
		.read_en  (read_en),
		.status   (status_d),
		.held_next(held_next)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WIDTH-1:0] left_word;
		logic [WIDTH-1:0] right_word;

		assign hit[i]   = (pos == IDX_W'(i));
		assign above[i] = (pos < IDX_W'(i));

		if (i == 0) begin : g_first
			assign left_word = word_s1;
		end else begin : g_mid_left
			assign left_word = words[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_word = words[i];
		end else begin : g_mid_right
			assign right_word = words[i+1];
		end

		iirl_cell #(
			.WIDTH(WIDTH)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.hit       (hit[i]),
			.above     (above[i]),
			.left_word (left_word),
			.right_word(right_word),
			.new_word  (word_s1),
			.word      (words[i]),
			.read_part (parts[i])
		);
	end

	// Only the addressed cell can contribute a non-zero word, so an OR gathers the read.
	always_comb begin
		read_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			read_word = read_word | parts[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				held_q      <= held_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_value_q <= read_en ? iirl_pkg::VALUE_W'(read_word) : '0;
			status_q     <= status_d;
			fill_q       <= iirl_pkg::FILL_W'(held_next);
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign fill       = fill_q;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the indexed insert/remove list unit.
`timescale 1ns / 1ps

module tb;

	import iirl_pkg::*;

	localparam int LIST_DEPTH  = DEPTH_DEF;
	localparam int LIST_GEN    = 0;
	localparam int LIST_CHK    = 1;
	localparam int STALL_LIMIT = 5000;
	localparam int RANDOM_PER_PHASE = 282;

	typedef struct packed {
		logic [ACTION_W-1:0]       act;
		logic signed [INDEX_W-1:0] pos;
		logic [VALUE_W-1:0]        word;
	} list_request_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  read_value;
		logic [STATUS_W-1:0] status;
		logic [FILL_W-1:0]   fill;
	} list_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [ACTION_W-1:0]        action = '0;
	logic signed [INDEX_W-1:0]  index = '0;
	logic [VALUE_W-1:0]         value = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [VALUE_W-1:0]         read_value;
	logic [STATUS_W-1:0]        status;
	logic [FILL_W-1:0]          fill;

	// Two copies of the list: one tracks what the stimulus has queued, one follows
	// the requests the block has actually taken.
	logic [VALUE_W-1:0] slot_words [2][LIST_DEPTH];
	int                 word_count [2] = '{0, 0};

	list_request_t list_requests [$];
	list_result_t  due_results [$];
	list_request_t next_req;
	list_result_t  due_res;

	logic req_fire = 1'b0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   fail_count = 0;
	int   quiet_cycles = 0;
	bit   grow_mode = 1'b1;
	int   fill_target = LIST_DEPTH;

	indexed_insert_remove_list_unit #(
		.DEPTH(LIST_DEPTH),
		.WIDTH(VALUE_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.index(index),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.read_value(read_value),
		.status(status),
		.fill(fill)
	);

	always #1 clk = ~clk;

	function automatic list_result_t step_list(input int sel, input logic [ACTION_W-1:0] act,
			input logic signed [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] word);
		list_result_t res;
		int pos;
		int held;
		held = word_count[sel];
		pos = idx;
		if (pos < 0)
			pos = pos + held;
		res.read_value = '0;
		res.status = ST_OK;
		case (act)
			ACT_INSERT: begin
				if (pos < 0 || pos > held)
					res.status = ST_RANGE;
				else if (held >= LIST_DEPTH)
					res.status = ST_FULL;
				else begin
					for (int i = held; i > pos; i--)
						slot_words[sel][i] = slot_words[sel][i-1];
					slot_words[sel][pos] = word;
					held++;
				end
			end
			ACT_READ, ACT_WRITE, ACT_REMOVE, ACT_POP: begin
				if (pos < 0)
					res.status = ST_RANGE;
				else if (pos >= held)
					res.status = (held == 0) ? ST_EMPTY : ST_RANGE;
				else begin
					if (act == ACT_READ || act == ACT_POP)
						res.read_value = slot_words[sel][pos];
					if (act == ACT_WRITE)
						slot_words[sel][pos] = word;
					if (act == ACT_REMOVE || act == ACT_POP) begin
						for (int i = pos + 1; i < held; i++)
							slot_words[sel][i-1] = slot_words[sel][i];
						held--;
					end
				end
			end
			ACT_CLEAR: held = 0;
			default: ;
		endcase
		word_count[sel] = held;
		res.fill = FILL_W'(held);
		return res;
	endfunction

	task automatic queue_request(input logic [ACTION_W-1:0] act,
			input logic signed [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] word);
		list_requests.push_back('{act, idx, word});
		void'(step_list(LIST_GEN, act, idx, word));
	endtask

	// Most requests are well formed against the queued fill level, which swings
	// between empty and full; a few are noise or deliberately out of range.
	task automatic queue_random_request();
		int h;
		int r;
		int q;
		int p;
		logic [ACTION_W-1:0] act;
		h = word_count[LIST_GEN];
		if (grow_mode ? (h >= fill_target && (fill_target < LIST_DEPTH || $urandom_range(0, 3) == 0))
				: (h <= fill_target)) begin
			grow_mode = !grow_mode;
			if (grow_mode)
				fill_target = $urandom_range(0, 1) ? LIST_DEPTH : $urandom_range(1, LIST_DEPTH);
			else
				fill_target = $urandom_range(0, 1) ? 0 : $urandom_range(0, LIST_DEPTH - 1);
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			queue_request(ACTION_W'($urandom_range(0, 7)), INDEX_W'($urandom_range(0, 255)),
				$urandom());
		end else if (r < 6) begin
			queue_request(ACT_CLEAR, INDEX_W'($urandom_range(0, 255)), $urandom());
		end else begin
			r = $urandom_range(0, 99);
			if (grow_mode)
				act = (r < 55) ? ACT_INSERT : (r < 70) ? ACT_READ : (r < 85) ? ACT_WRITE :
					(r < 93) ? ACT_REMOVE : ACT_POP;
			else
				act = (r < 15) ? ACT_INSERT : (r < 35) ? ACT_READ : (r < 50) ? ACT_WRITE :
					(r < 75) ? ACT_REMOVE : ACT_POP;
			if (act == ACT_INSERT)
				p = $urandom_range(0, h);
			else
				p = (h == 0) ? 0 : $urandom_range(0, h - 1);
			q = $urandom_range(0, 99);
			if (q < 6)
				p = h + ((act == ACT_INSERT) ? 1 : 0) + $urandom_range(0, 2);
			else if (q < 10)
				p = -h - $urandom_range(1, 3);
			else if (q < 55 && p < h)
				p = p - h;
			queue_request(act, INDEX_W'(p), $urandom());
		end
	endtask

	task automatic wait_until_drained();
		while (list_requests.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
	endtask

	// Driver: a request stays on the port until it is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			if (!in_valid || req_fire) begin
				if (list_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					next_req = list_requests.pop_front();
					in_valid <= 1'b1;
					action <= next_req.act;
					index <= next_req.pos;
					value <= next_req.word;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predicts on each taken request and checks each taken result.
	always @(posedge clk) begin
		req_fire <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready)
				due_results.push_back(step_list(LIST_CHK, action, index, value));
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					due_res = due_results.pop_front();
					if (read_value !== due_res.read_value) begin
						$error("read_value: expected %h, got %h", due_res.read_value, read_value);
						fail_count++;
					end
					if (status !== due_res.status) begin
						$error("status: expected %0d, got %0d", due_res.status, status);
						fail_count++;
					end
					if (fill !== due_res.fill) begin
						$error("fill: expected %0d, got %0d", due_res.fill, fill);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
				1: begin send_idle_pct = 46; recv_idle_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_idle_pct = 46; end
				default: begin send_idle_pct = 6; recv_idle_pct = 6; end
			endcase
			if (phase == 0) begin
				// Empty-list access, negative or past-end indices, valid ops, bad codes, clear.
				queue_request(ACT_READ, 8'sd0, 32'h0);
				queue_request(ACT_REMOVE, -8'sd1, 32'h0);
				queue_request(ACT_POP, 8'sd0, 32'h0);
				queue_request(ACT_WRITE, 8'sd0, 32'hFFFF_FFFF);
				queue_request(ACT_INSERT, 8'sd1, 32'h1);
				queue_request(ACT_INSERT, -8'sd1, 32'h2);
				queue_request(ACT_INSERT, 8'sd64, 32'h3);
				queue_request(ACT_INSERT, -8'sd64, 32'h4);
				queue_request(ACT_INSERT, 8'sd0, 32'hFFFF_FFFF);
				queue_request(ACT_INSERT, 8'sd1, 32'h0000_0000);
				queue_request(ACT_INSERT, 8'sd0, 32'hA5A5_5A5A);
				queue_request(ACT_READ, -8'sd1, 32'h0);
				queue_request(ACT_READ, -8'sd3, 32'h0);
				queue_request(ACT_READ, -8'sd4, 32'h0);
				queue_request(ACT_WRITE, 8'sd1, 32'h1234_5678);
				queue_request(ACT_READ, 8'sd1, 32'h0);
				queue_request(ACT_POP, 8'sd0, 32'h0);
				queue_request(ACT_REMOVE, -8'sd1, 32'h0);
				queue_request(ACT_READ, 8'sd5, 32'h0);
				queue_request(ACT_INSERT, 8'sd127, 32'h5);
				queue_request(3'd6, 8'sd127, 32'hFFFF_FFFF);
				queue_request(3'd7, -8'sd128, 32'h0);
				queue_request(ACT_CLEAR, 8'sd0, 32'h0);
				queue_request(ACT_READ, 8'sd0, 32'h0);
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				queue_random_request();
			// The sender holds off here until every outstanding result is back.
			wait_until_drained();
		end
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
